[design/clts_pkg.sv]
// Shared types, transfer codes and cursor helpers for the character-LCD
// terminal sequencer. No dependencies; every other design file imports it.
`default_nettype none

package clts_pkg;

  // Host command codes.
  typedef enum logic [2:0] {
    OP_PUT_CHAR   = 3'd0,
    OP_SET_CURSOR = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_HOME       = 3'd3,
    OP_LOAD_GLYPH = 3'd4,
    OP_INIT       = 3'd5
  } op_e;

  // Kinds of work handed from the front end to the back end.
  typedef enum logic [2:0] {
    JOB_CHAR   = 3'd0,
    JOB_CURSOR = 3'd1,
    JOB_CLEAR  = 3'd2,
    JOB_HOME   = 3'd3,
    JOB_GLYPH  = 3'd4,
    JOB_INIT   = 3'd5
  } job_e;

  // One classified command waiting for the back end.
  typedef struct packed {
    job_e        kind;
    logic [7:0]  first_code;  // character byte or CGRAM address command
    logic        mv_ok;       // a cursor address command follows
    logic [6:0]  mv_addr;     // DDRAM address of that command
    logic [63:0] rows;        // glyph rows, row 0 in the low byte
    logic        backlight;
  } job_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LINE_COUNT  = 2'd0;
  localparam logic [1:0] CFG_LINE_LENGTH = 2'd1;
  localparam logic [1:0] CFG_BUSY_WAIT   = 2'd2;

  localparam logic [2:0] LINE_COUNT_RST  = 3'd2;
  localparam logic [4:0] LINE_LENGTH_RST = 5'd16;
  localparam logic [9:0] BUSY_WAIT_RST   = 10'd120;

  // Special characters of put-char.
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_RETURN  = 8'd13;

  // Display command bytes.
  localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] LCD_SET_CGRAM  = 8'h40;
  localparam logic [7:0] LCD_WAKE       = 8'h30;
  localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
  localparam logic [7:0] LCD_DISPLAY_ON = 8'h0D;
  localparam logic [7:0] LCD_CLEAR      = 8'h01;
  localparam logic [7:0] LCD_HOME       = 8'h02;
  localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;

  // DDRAM base address of each line.
  localparam logic [6:0] LINE1_BASE = 7'h00;
  localparam logic [6:0] LINE2_BASE = 7'h40;
  localparam logic [6:0] LINE3_BASE = 7'h14;
  localparam logic [6:0] LINE4_BASE = 7'h54;

  localparam logic [2:0] MAX_LINES = 3'd4;

  // Waits in microseconds.
  localparam logic [16:0] WAIT_POWER_ON_US = 17'd100000;
  localparam logic [9:0]  WAIT_SHORT_US    = 10'd50;
  localparam logic [9:0]  WAIT_LONG_US     = 10'd1000;

  // True when a cursor position lies on the configured display.
  function automatic logic cursor_ok(input logic [2:0] ln, input logic [5:0] col,
                                     input logic [2:0] lc, input logic [4:0] ll);
    cursor_ok = (ln != 3'd0) && (ln <= lc) && (ln <= MAX_LINES) &&
                (col != 6'd0) && (col <= {1'b0, ll});
  endfunction

  // DDRAM address of a valid cursor position.
  function automatic logic [6:0] cursor_addr(input logic [2:0] ln, input logic [5:0] col);
    logic [6:0] base;
    case (ln)
      3'd1:    base = LINE1_BASE;
      3'd2:    base = LINE2_BASE;
      3'd3:    base = LINE3_BASE;
      default: base = LINE4_BASE;
    endcase
    cursor_addr = base + {1'b0, col} - 7'd1;
  endfunction

endpackage

`default_nettype wire

[design/clts_front.sv]
// Front end: accepts host commands, tracks cursor and backlight, and turns
// each command into at most one job for the queue. Depends on clts_pkg.
`default_nettype none

module clts_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [2:0]        line_count_i,
  input  logic [4:0]        line_length_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        op_i,
  input  logic [7:0]        char_code_i,
  input  logic [2:0]        line_i,
  input  logic [5:0]        column_i,
  input  logic [3:0]        glyph_slot_i,
  input  logic [63:0]       pattern_rows_i,
  input  logic              queue_full_i,
  output logic              push_o,
  output clts_pkg::job_t    job_o
);
  import clts_pkg::*;

  logic [2:0] cur_line_q, cur_line_d;
  logic [4:0] cur_col_q, cur_col_d;
  logic       backlight_q, backlight_d;

  logic       accept;
  logic       mv_try, mv_ok;
  logic [2:0] mv_line;
  logic [5:0] mv_col;
  logic       push_always, push_on_move;
  logic [5:0] col_next;
  logic [3:0] line_next;
  job_e       kind;
  logic [7:0] first_code;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the command and work out the cursor it leaves behind.
  always_comb begin
    cur_line_d   = cur_line_q;
    cur_col_d    = cur_col_q;
    backlight_d  = backlight_q;
    mv_try       = 1'b0;
    mv_line      = cur_line_q;
    mv_col       = 6'd1;
    push_always  = 1'b0;
    push_on_move = 1'b0;
    kind         = JOB_CURSOR;
    first_code   = char_code_i;
    col_next     = 6'd0;
    line_next    = 4'd0;
    case (op_e'(op_i))
      OP_PUT_CHAR: begin
        if (char_code_i == CHAR_NEWLINE) begin
          push_on_move = 1'b1;
          if (cur_line_q < line_count_i) begin
            cur_line_d = cur_line_q + 3'd1;
            mv_try     = 1'b1;
            mv_line    = cur_line_q + 3'd1;
          end
        end else if (char_code_i == CHAR_TAB) begin
          push_on_move = 1'b1;
          col_next = cur_col_q[0] ? {1'b0, cur_col_q} + 6'd1 : {1'b0, cur_col_q} + 6'd2;
          if (col_next < {1'b0, line_length_i}) begin
            mv_try = 1'b1;
            mv_col = col_next;
          end
        end else if (char_code_i == CHAR_RETURN) begin
          push_on_move = 1'b1;
          mv_try       = 1'b1;
        end else begin
          // Printable data; past the end, wrap to the start of the next line, or of line 1.
          kind        = JOB_CHAR;
          push_always = 1'b1;
          col_next    = {1'b0, cur_col_q} + 6'd1;
          if (col_next > {1'b0, line_length_i}) begin
            line_next = {1'b0, cur_line_q} + 4'd1;
            if (line_next > {1'b0, line_count_i}) begin
              line_next = 4'd1;
            end
            cur_col_d  = 5'd1;
            cur_line_d = line_next[2:0];
            mv_try     = 1'b1;
            mv_line    = line_next[2:0];
          end else begin
            cur_col_d = col_next[4:0];
          end
        end
      end
      OP_SET_CURSOR: begin
        push_on_move = 1'b1;
        mv_try       = 1'b1;
        mv_line      = line_i;
        mv_col       = column_i;
      end
      OP_CLEAR: begin
        kind        = JOB_CLEAR;
        push_always = 1'b1;
        cur_line_d  = 3'd1;
        cur_col_d   = 5'd1;
      end
      OP_HOME: begin
        kind        = JOB_HOME;
        push_always = 1'b1;
        cur_line_d  = 3'd1;
        cur_col_d   = 5'd1;
      end
      OP_LOAD_GLYPH: begin
        if (!glyph_slot_i[3]) begin
          kind        = JOB_GLYPH;
          push_always = 1'b1;
          first_code  = LCD_SET_CGRAM | {2'b00, glyph_slot_i[2:0], 3'b000};
          mv_try      = 1'b1;
          mv_col      = {1'b0, cur_col_q};
        end
      end
      OP_INIT: begin
        kind        = JOB_INIT;
        push_always = 1'b1;
        backlight_d = 1'b1;
      end
      default: begin
      end
    endcase

    // A cursor move that passes the check sets the cursor to its target.
    mv_ok = mv_try && cursor_ok(mv_line, mv_col, line_count_i, line_length_i);
    if (mv_ok) begin
      cur_line_d = mv_line;
      cur_col_d  = mv_col[4:0];
    end
  end

  assign push_o = accept && (push_always || (push_on_move && mv_ok));

  always_comb begin
    job_o.kind       = kind;
    job_o.first_code = first_code;
    job_o.mv_ok      = mv_ok;
    job_o.mv_addr    = cursor_addr(mv_line, mv_col);
    job_o.rows       = pattern_rows_i;
    job_o.backlight  = backlight_d;
  end

  // Cursor and backlight state, updated on each accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_line_q  <= 3'd1;
      cur_col_q   <= 5'd1;
      backlight_q <= 1'b0;
    end else if (accept) begin
      cur_line_q  <= cur_line_d;
      cur_col_q   <= cur_col_d;
      backlight_q <= backlight_d;
    end
  end

endmodule

`default_nettype wire

[design/clts_queue.sv]
// Short job queue between the front end and the back end.
// Depends on clts_pkg for the job type.
`default_nettype none

module clts_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clts_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output clts_pkg::job_t head_o
);
  import clts_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue written while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_valid_o)
    else $error("queue read while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("queue fill count out of range");
`endif

endmodule

`default_nettype wire

[design/clts_back.sv]
// Back end: expands each queued job into display transfers, one per cycle
// unless the output stalls, into an output register. Depends on clts_pkg.
`default_nettype none

module clts_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [9:0]     busy_wait_i,
  input  logic           head_valid_i,
  input  clts_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           reg_select_o,
  output logic [7:0]     code_o,
  output logic           high_nibble_only_o,
  output logic [16:0]    wait_before_us_o,
  output logic [9:0]     wait_after_us_o,
  output logic           backlight_o,
  output logic           last_o
);
  import clts_pkg::*;

  logic [3:0]  step_q, step_d;
  logic        out_valid_q;
  logic        load;

  logic        rs;
  logic [7:0]  code;
  logic        hno;
  logic [16:0] wait_before;
  logic [9:0]  wait_after;
  logic        xfer_last;
  logic [2:0]  row_sel;
  logic [7:0]  cursor_cmd;

  logic        reg_select_q;
  logic [7:0]  code_q;
  logic        hno_q;
  logic [16:0] wait_before_q;
  logic [9:0]  wait_after_q;
  logic        backlight_q;
  logic        last_q;

  assign load       = head_valid_i && (!out_valid_q || out_ready_i);
  assign row_sel    = step_q[2:0] - 3'd1;
  assign cursor_cmd = LCD_SET_DDRAM | {1'b0, head_i.mv_addr};

  // Transfer for the current step of the job at the queue head.
  always_comb begin
    rs          = 1'b0;
    code        = cursor_cmd;
    hno         = 1'b0;
    wait_before = {7'd0, busy_wait_i};
    wait_after  = 10'd0;
    xfer_last   = 1'b1;
    case (head_i.kind)
      JOB_CHAR: begin
        if (step_q == 4'd0) begin
          rs        = 1'b1;
          code      = head_i.first_code;
          xfer_last = !head_i.mv_ok;
        end
      end
      JOB_CURSOR: begin
      end
      JOB_CLEAR: begin
        code       = LCD_CLEAR;
        wait_after = WAIT_SHORT_US;
      end
      JOB_HOME: begin
        code = LCD_HOME;
      end
      JOB_GLYPH: begin
        if (step_q == 4'd0) begin
          code      = head_i.first_code;
          xfer_last = 1'b0;
        end else if (step_q <= 4'd8) begin
          rs        = 1'b1;
          code      = head_i.rows[{row_sel, 3'b000} +: 8];
          xfer_last = (step_q == 4'd8) && !head_i.mv_ok;
        end
      end
      JOB_INIT: begin
        xfer_last = 1'b0;
        case (step_q)
          4'd0: begin
            code        = LCD_WAKE;
            hno         = 1'b1;
            wait_before = WAIT_POWER_ON_US;
            wait_after  = WAIT_SHORT_US;
          end
          4'd1, 4'd2: begin
            code        = LCD_FUNC_SET;
            wait_before = 17'd0;
            wait_after  = WAIT_SHORT_US;
          end
          4'd3: begin
            code = LCD_DISPLAY_ON;
          end
          4'd4: begin
            code = LCD_CLEAR;
          end
          default: begin
            code       = LCD_ENTRY_MODE;
            wait_after = WAIT_LONG_US;
            xfer_last  = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Step counter; the job leaves the queue with its final transfer.
  always_comb begin
    step_d = step_q;
    pop_o  = 1'b0;
    if (load) begin
      if (xfer_last) begin
        step_d = 4'd0;
        pop_o  = 1'b1;
      end else begin
        step_d = step_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      reg_select_q  <= rs;
      code_q        <= code;
      hno_q         <= hno;
      wait_before_q <= wait_before;
      wait_after_q  <= wait_after;
      backlight_q   <= head_i.backlight;
      last_q        <= xfer_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign reg_select_o       = reg_select_q;
  assign code_o             = code_q;
  assign high_nibble_only_o = hno_q;
  assign wait_before_us_o   = wait_before_q;
  assign wait_after_us_o    = wait_after_q;
  assign backlight_o        = backlight_q;
  assign last_o             = last_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) (step_q != 4'd0) |-> head_valid_i)
    else $error("sequencer mid-job without a queued job");
  assert property (@(posedge clk_i) disable iff (!rst_ni) step_q <= 4'd9)
    else $error("sequencer step out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (load && xfer_last) |=> step_q == 4'd0)
    else $error("step counter not cleared after final transfer");
`endif

endmodule

`default_nettype wire

[design/char_lcd_terminal_sequencer_core.sv]
// Character-LCD terminal sequencer, 4-bit HD44780-style bus. Each accepted
// command yields zero to ten display transfers, each a register select, a
// byte, a high-nibble-only flag, waits before and after, the backlight level
// and a last flag on the final transfer of the command. The front end takes
// one command per cycle while its job queue (QueueDepth entries) has room;
// the back end sends one transfer per cycle unless the output stalls, so a
// command yields 1 transfer (put char, set cursor, clear, home), 1 or 2
// (wrapping put char), 9 or 10 (glyph load) or 6 (init). Each job passes
// the job queue, then the output register. Commands with no transfer
// (dropped cursor moves, bad glyph slots, unused opcodes) are never queued.
// Configuration must be written while no transfer is pending.
`default_nettype none

module char_lcd_terminal_sequencer_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  char_code_i,
  input  logic [2:0]  line_i,
  input  logic [5:0]  column_i,
  input  logic [3:0]  glyph_slot_i,
  input  logic [63:0] pattern_rows_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        reg_select_o,
  output logic [7:0]  code_o,
  output logic        high_nibble_only_o,
  output logic [16:0] wait_before_us_o,
  output logic [9:0]  wait_after_us_o,
  output logic        backlight_o,
  output logic        last_o
);
  import clts_pkg::*;

  logic [2:0] line_count_q;
  logic [4:0] line_length_q;
  logic [9:0] busy_wait_q;

  logic  push, full, pop, head_valid;
  job_t  push_job, head_job;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q  <= LINE_COUNT_RST;
      line_length_q <= LINE_LENGTH_RST;
      busy_wait_q   <= BUSY_WAIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LINE_COUNT:  line_count_q  <= cfg_data_i[2:0];
        CFG_LINE_LENGTH: line_length_q <= cfg_data_i[4:0];
        CFG_BUSY_WAIT:   busy_wait_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  clts_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .line_count_i   (line_count_q),
    .line_length_i  (line_length_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .char_code_i    (char_code_i),
    .line_i         (line_i),
    .column_i       (column_i),
    .glyph_slot_i   (glyph_slot_i),
    .pattern_rows_i (pattern_rows_i),
    .queue_full_i   (full),
    .push_o         (push),
    .job_o          (push_job)
  );

  clts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_job)
  );

  clts_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .busy_wait_i        (busy_wait_q),
    .head_valid_i       (head_valid),
    .head_i             (head_job),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .reg_select_o       (reg_select_o),
    .code_o             (code_o),
    .high_nibble_only_o (high_nibble_only_o),
    .wait_before_us_o   (wait_before_us_o),
    .wait_after_us_o    (wait_after_us_o),
    .backlight_o        (backlight_o),
    .last_o             (last_o)
  );

endmodule

`default_nettype wire

[tb/char_lcd_terminal_sequencer_core_test.sv]
// Self-checking testbench for the character-LCD terminal sequencer core.
// Depends on clts_pkg and char_lcd_terminal_sequencer_core; needs nothing else.
`timescale 1ns / 100ps

module char_lcd_terminal_sequencer_core_test;
  import clts_pkg::*;

  // Opcodes the block must ignore.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int CYCLE_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 120;
  localparam int SEGMENTS      = 4;

  // One host command as driven on the input channel.
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  ch;
    logic [2:0]  ln;
    logic [5:0]  col;
    logic [3:0]  slot;
    logic [63:0] rows;
  } lcd_cmd_t;

  // One display transfer as seen on the output channel.
  typedef struct packed {
    logic        rs;
    logic [7:0]  code;
    logic        hno;
    logic [16:0] wait_before;
    logic [9:0]  wait_after;
    logic        backlight;
    logic        last;
  } lcd_xfer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [9:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  op_i;
  logic [7:0]  char_code_i;
  logic [2:0]  line_i;
  logic [5:0]  column_i;
  logic [3:0]  glyph_slot_i;
  logic [63:0] pattern_rows_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        reg_select_o;
  logic [7:0]  code_o;
  logic        high_nibble_only_o;
  logic [16:0] wait_before_us_o;
  logic [9:0]  wait_after_us_o;
  logic        backlight_o;
  logic        last_o;

  char_lcd_terminal_sequencer_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .char_code_i        (char_code_i),
    .line_i             (line_i),
    .column_i           (column_i),
    .glyph_slot_i       (glyph_slot_i),
    .pattern_rows_i     (pattern_rows_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .reg_select_o       (reg_select_o),
    .code_o             (code_o),
    .high_nibble_only_o (high_nibble_only_o),
    .wait_before_us_o   (wait_before_us_o),
    .wait_after_us_o    (wait_after_us_o),
    .backlight_o        (backlight_o),
    .last_o             (last_o)
  );

  // Shadow copy of the configuration and the cursor state.
  logic [2:0] cfg_lines;
  logic [4:0] cfg_len;
  logic [9:0] cfg_busy;
  logic [2:0] cur_line;
  logic [4:0] cur_col;
  logic       lamp_on;

  lcd_xfer_t step_xfers[$];
  lcd_xfer_t transfers_due[$];

  int in_idle_pct   = 11;
  int out_stall_pct = 11;
  int mismatches    = 0;
  int cycles        = 0;
  int xfers_seen    = 0;

  // 12 ns clock.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR cycle %0d transfer %0d: %s", cycles, xfers_seen, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Display transfer prediction
  // ---------------------------------------------------------------------

  function automatic void add_xfer(input logic rs, input logic [7:0] code, input logic hno,
                                   input logic [16:0] wb, input logic [9:0] wa);
    lcd_xfer_t x;
    x.rs          = rs;
    x.code        = code;
    x.hno         = hno;
    x.wait_before = wb;
    x.wait_after  = wa;
    x.backlight   = 1'b0;
    x.last        = 1'b0;
    step_xfers.push_back(x);
  endfunction

  // Cursor move: emits a DDRAM address command only when the target is on
  // the display; otherwise the move is dropped and the cursor is untouched.
  function automatic void goto_cursor(input int ln, input int col);
    logic [6:0] base;
    logic [6:0] addr;
    if (ln < 1 || ln > int'(cfg_lines) || ln > 4 || col < 1 || col > int'(cfg_len))
      return;
    case (ln)
      1:       base = LINE1_BASE;
      2:       base = LINE2_BASE;
      3:       base = LINE3_BASE;
      default: base = LINE4_BASE;
    endcase
    addr = base + 7'(col) - 7'd1;
    add_xfer(1'b0, LCD_SET_DDRAM | {1'b0, addr}, 1'b0, 17'(cfg_busy), 10'd0);
    cur_line = 3'(ln);
    cur_col  = 5'(col);
  endfunction

  function automatic void predict_put_char(input logic [7:0] ch);
    int t;
    int nl;
    if (ch == CHAR_NEWLINE) begin
      if (cur_line < cfg_lines) begin
        cur_line = cur_line + 3'd1;
        goto_cursor(cur_line, 1);
      end
    end else if (ch == CHAR_TAB) begin
      // Next even column.
      t = (cur_col[0] == 1'b0) ? int'(cur_col) + 2 : (int'(cur_col) / 2 + 1) * 2;
      if (t < int'(cfg_len))
        goto_cursor(cur_line, t);
    end else if (ch == CHAR_RETURN) begin
      goto_cursor(cur_line, 1);
    end else begin
      add_xfer(1'b1, ch, 1'b0, 17'(cfg_busy), 10'd0);
      t = int'(cur_col) + 1;
      if (t > int'(cfg_len)) begin
        // Wrap to column 1 of the next line, or back to line 1.
        nl = int'(cur_line) + 1;
        if (nl > int'(cfg_lines))
          nl = 1;
        cur_col  = 5'd1;
        cur_line = 3'(nl);
        goto_cursor(cur_line, cur_col);
      end else begin
        cur_col = 5'(t);
      end
    end
  endfunction

  // Works out the transfers of one accepted command and queues them.
  function automatic void predict_transfers(input lcd_cmd_t c);
    lcd_xfer_t x;
    step_xfers.delete();
    case (c.op)
      OP_PUT_CHAR: predict_put_char(c.ch);
      OP_SET_CURSOR: goto_cursor(c.ln, c.col);
      OP_CLEAR: begin
        add_xfer(1'b0, LCD_CLEAR, 1'b0, 17'(cfg_busy), WAIT_SHORT_US);
        cur_line = 3'd1;
        cur_col  = 5'd1;
      end
      OP_HOME: begin
        add_xfer(1'b0, LCD_HOME, 1'b0, 17'(cfg_busy), 10'd0);
        cur_line = 3'd1;
        cur_col  = 5'd1;
      end
      OP_LOAD_GLYPH: begin
        if (c.slot <= 4'd7) begin
          add_xfer(1'b0, LCD_SET_CGRAM | {2'b00, c.slot[2:0], 3'b000}, 1'b0,
                   17'(cfg_busy), 10'd0);
          for (int k = 0; k < 8; k++)
            add_xfer(1'b1, c.rows[8*k +: 8], 1'b0, 17'(cfg_busy), 10'd0);
          goto_cursor(cur_line, cur_col);
        end
      end
      OP_INIT: begin
        lamp_on = 1'b1;
        add_xfer(1'b0, LCD_WAKE, 1'b1, WAIT_POWER_ON_US, WAIT_SHORT_US);
        add_xfer(1'b0, LCD_FUNC_SET, 1'b0, 17'd0, WAIT_SHORT_US);
        add_xfer(1'b0, LCD_FUNC_SET, 1'b0, 17'd0, WAIT_SHORT_US);
        add_xfer(1'b0, LCD_DISPLAY_ON, 1'b0, 17'(cfg_busy), 10'd0);
        add_xfer(1'b0, LCD_CLEAR, 1'b0, 17'(cfg_busy), 10'd0);
        add_xfer(1'b0, LCD_ENTRY_MODE, 1'b0, 17'(cfg_busy), WAIT_LONG_US);
      end
      default: ;
    endcase
    // Backlight level after the command, and the last flag on its final transfer.
    foreach (step_xfers[k]) begin
      x           = step_xfers[k];
      x.backlight = lamp_on;
      x.last      = (k == step_xfers.size() - 1);
      transfers_due.push_back(x);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Output side: random stalls and the transfer check
  // ---------------------------------------------------------------------

  task automatic check_transfer();
    lcd_xfer_t want;
    if (transfers_due.size() == 0) begin
      report_mismatch($sformatf("unexpected transfer, code %02h", code_o));
      return;
    end
    want = transfers_due.pop_front();
    if (reg_select_o !== want.rs)
      report_mismatch($sformatf("reg_select %b, expected %b", reg_select_o, want.rs));
    if (code_o !== want.code)
      report_mismatch($sformatf("code %02h, expected %02h", code_o, want.code));
    if (high_nibble_only_o !== want.hno)
      report_mismatch($sformatf("high_nibble_only %b, expected %b",
                                high_nibble_only_o, want.hno));
    if (wait_before_us_o !== want.wait_before)
      report_mismatch($sformatf("wait_before_us %0d, expected %0d",
                                wait_before_us_o, want.wait_before));
    if (wait_after_us_o !== want.wait_after)
      report_mismatch($sformatf("wait_after_us %0d, expected %0d",
                                wait_after_us_o, want.wait_after));
    if (backlight_o !== want.backlight)
      report_mismatch($sformatf("backlight %b, expected %b", backlight_o, want.backlight));
    if (last_o !== want.last)
      report_mismatch($sformatf("last %b, expected %b", last_o, want.last));
  endtask

  // Check the transaction taken at this edge, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      xfers_seen++;
      check_transfer();
    end
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // A command with random content in every field; callers override what matters.
  function automatic lcd_cmd_t rand_cmd(input logic [2:0] op);
    lcd_cmd_t c;
    c.op   = op;
    c.ch   = 8'($urandom);
    c.ln   = 3'($urandom);
    c.col  = 6'($urandom);
    c.slot = 4'($urandom);
    c.rows = {$urandom, $urandom};
    return c;
  endfunction

  // Sends one command; valid stays high on return so back-to-back commands
  // need no second assignment in the same time step.
  task automatic send_cmd(input lcd_cmd_t c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= c.op;
    char_code_i    <= c.ch;
    line_i         <= c.ln;
    column_i       <= c.col;
    glyph_slot_i   <= c.slot;
    pattern_rows_i <= c.rows;
    @(posedge clk_i);
    while (!in_ready_o)
      @(posedge clk_i);
    predict_transfers(c);
  endtask

  // Holds off the sender until every queued transfer has arrived, then lets
  // commands that cause no transfer leave the block.
  task automatic wait_all_done();
    in_valid_i <= 1'b0;
    while (transfers_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_LINE_COUNT:  cfg_lines = data[2:0];
      CFG_LINE_LENGTH: cfg_len   = data[4:0];
      CFG_BUSY_WAIT:   cfg_busy  = data;
      default: ;
    endcase
  endtask

  // Writes all three registers; only called while the block is idle.
  task automatic set_config(input logic [2:0] lines, input logic [4:0] len,
                            input logic [9:0] busy);
    write_reg(CFG_LINE_COUNT, {7'd0, lines});
    write_reg(CFG_LINE_LENGTH, {5'd0, len});
    write_reg(CFG_BUSY_WAIT, busy);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_cursor(input logic [2:0] ln, input logic [5:0] col);
    lcd_cmd_t c;
    c     = rand_cmd(OP_SET_CURSOR);
    c.ln  = ln;
    c.col = col;
    send_cmd(c);
  endtask

  task automatic send_char(input logic [7:0] ch);
    lcd_cmd_t c;
    c    = rand_cmd(OP_PUT_CHAR);
    c.ch = ch;
    send_cmd(c);
  endtask

  task automatic send_glyph(input logic [3:0] slot, input logic [63:0] rows);
    lcd_cmd_t c;
    c      = rand_cmd(OP_LOAD_GLYPH);
    c.slot = slot;
    c.rows = rows;
    send_cmd(c);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Data before and after init: backlight off, then on; byte extremes.
  task automatic test_power_up();
    send_char(8'h00);
    send_cmd(rand_cmd(OP_INIT));
    send_char(8'hFF);
  endtask

  // Valid and invalid set-cursor targets, then a wrap from the last cell.
  task automatic test_cursor_moves();
    send_cursor(3'd2, 6'd16);
    send_cursor(3'd0, 6'd1);
    send_cursor(3'd3, 6'd1);
    send_cursor(3'd1, 6'd0);
    send_cursor(3'd1, 6'd17);
    send_cursor(3'd7, 6'd63);
    send_char(8'h7F);
  endtask

  // Newline, newline on the last line, tab, carriage return, clear and home.
  task automatic test_control_chars();
    send_char(CHAR_NEWLINE);
    send_char(CHAR_NEWLINE);
    send_char(CHAR_TAB);
    send_char(CHAR_RETURN);
    send_cmd(rand_cmd(OP_CLEAR));
    send_cmd(rand_cmd(OP_HOME));
  endtask

  // Glyph loads at the slot extremes, including slots out of range.
  task automatic test_glyphs();
    send_glyph(4'd0, 64'h0);
    send_glyph(4'd7, '1);
    send_glyph(4'd8, {$urandom, $urandom});
    send_glyph(4'd15, {$urandom, $urandom});
  endtask

  task automatic test_spare_ops();
    send_cmd(rand_cmd(OP_SPARE_6));
    send_cmd(rand_cmd(OP_SPARE_7));
  endtask

  // Smallest and largest display geometry, then a shrink that strands the cursor.
  task automatic test_config_extremes();
    wait_all_done();
    set_config(3'd1, 5'd1, 10'd0);
    send_char(8'h41);
    send_char(CHAR_NEWLINE);
    wait_all_done();
    set_config(3'd4, 5'd20, 10'd1000);
    send_cursor(3'd4, 6'd20);
    send_char(8'h42);
    send_cursor(3'd4, 6'd20);
    wait_all_done();
    set_config(3'd2, 5'd8, 10'd1000);
    send_glyph(4'd1, {$urandom, $urandom});
    send_char(8'h43);
  endtask

  // Mostly well-formed traffic with random content, in several settings.
  task automatic test_random_traffic();
    lcd_cmd_t c;
    int pick;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_all_done();
      set_config(3'($urandom_range(4, 1)), 5'($urandom_range(20, 1)),
                 10'($urandom_range(1000, 0)));
      // One segment runs with no idling on either side.
      in_idle_pct   = (seg == 2) ? 0 : 11;
      out_stall_pct = (seg == 2) ? 0 : 11;
      for (int n = 0; n < RANDOM_ITEMS / SEGMENTS; n++) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          c = rand_cmd(OP_PUT_CHAR);
          case ($urandom_range(19))
            0: c.ch = CHAR_NEWLINE;
            1: c.ch = CHAR_TAB;
            2: c.ch = CHAR_RETURN;
            default: ;
          endcase
        end else if (pick < 70) begin
          c = rand_cmd(OP_SET_CURSOR);
          if ($urandom_range(99) < 80) begin
            c.ln  = 3'($urandom_range(int'(cfg_lines), 1));
            c.col = 6'($urandom_range(int'(cfg_len), 1));
          end
        end else if (pick < 75) begin
          c = rand_cmd(OP_CLEAR);
        end else if (pick < 80) begin
          c = rand_cmd(OP_HOME);
        end else if (pick < 90) begin
          c = rand_cmd(OP_LOAD_GLYPH);
          if ($urandom_range(99) < 85)
            c.slot[3] = 1'b0;
        end else if (pick < 96) begin
          c = rand_cmd(OP_INIT);
        end else begin
          c = rand_cmd($urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7);
        end
        send_cmd(c);
      end
    end
    in_idle_pct   = 11;
    out_stall_pct = 11;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= CFG_LINE_COUNT;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    op_i           <= OP_PUT_CHAR;
    char_code_i    <= '0;
    line_i         <= '0;
    column_i       <= '0;
    glyph_slot_i   <= '0;
    pattern_rows_i <= '0;
    cfg_lines = LINE_COUNT_RST;
    cfg_len   = LINE_LENGTH_RST;
    cfg_busy  = BUSY_WAIT_RST;
    cur_line  = 3'd1;
    cur_col   = 5'd1;
    lamp_on   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_up();
    test_cursor_moves();
    test_control_chars();
    test_glyphs();
    test_spare_ops();
    test_config_extremes();
    test_random_traffic();
    wait_all_done();

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[char_lcd_terminal_sequencer_core.f]
design/clts_pkg.sv
design/clts_front.sv
design/clts_queue.sv
design/clts_back.sv
design/char_lcd_terminal_sequencer_core.sv
tb/char_lcd_terminal_sequencer_core_test.sv
